[design/hsl2rgb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the HSL to RGB converter.
// No dependencies.
package hsl2rgb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int HUE_W         = 16;
  localparam int PCT_W         = 8;
  localparam int PCT_CLIP_W    = 7;
  localparam int HUE_MOD_W     = 9;
  localparam int BYTE_W        = 8;
  localparam int NUM_CH        = 3;
  localparam int QUEUE_DEPTH   = 2;

  localparam int DEG_FULL = 360;
  localparam int PCT_MAX  = 100;
  localparam int BYTE_MAX = 255;

  // reciprocal of 360 scaled by 2^HUE_W, for the hue modulo
  localparam int HUE_RECIP_W = 8;
  localparam logic [HUE_RECIP_W-1:0] HUE_RECIP = HUE_RECIP_W'((1 << HUE_W) / DEG_FULL);

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // segment of the piecewise linear curve
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_e;

  typedef seg_e [NUM_CH-1:0] seg_vec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[design/hsl2rgb_front.sv]
`timescale 1ns / 1ps
// Front end: clips and scales hue, saturation and lightness to fixed point,
// forms the channel hues and classifies each into its curve segment. Uses hsl2rgb_pkg.
module hsl2rgb_front #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          accept_i,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]                 hue_i,
  input  logic [hsl2rgb_pkg::PCT_W-1:0]                 saturation_i,
  input  logic [hsl2rgb_pkg::PCT_W-1:0]                 lightness_i,
  output logic                                          valid_o,
  output logic [FRAC_BITS:0]                            s_o,
  output logic [FRAC_BITS:0]                            l_o,
  output hsl2rgb_pkg::seg_vec_t                         seg_o,
  output logic [hsl2rgb_pkg::NUM_CH-1:0][FRAC_BITS:0]   m_o
);
  import hsl2rgb_pkg::*;

  localparam int LW  = FRAC_BITS + 1;
  localparam int PSH = PCT_CLIP_W + FRAC_BITS;
  localparam int HSH = HUE_MOD_W + FRAC_BITS;
  localparam logic [LW-1:0] ONE       = LW'(64'd1 << FRAC_BITS);
  localparam logic [LW-1:0] THIRD     = LW'((64'd1 << FRAC_BITS) / 3);
  localparam logic [LW-1:0] TWO3      = LW'((64'd2 << FRAC_BITS) / 3);
  localparam logic [LW-1:0] RECIP_PCT = LW'((64'd1 << PSH) / PCT_MAX);
  localparam logic [LW-1:0] RECIP_DEG = LW'((64'd1 << HSH) / DEG_FULL);
  localparam int HP_W = HUE_W + HUE_RECIP_W;

  // stage A: clip, hue quotient estimate
  logic                   a_vld_q;
  logic [HUE_W-1:0]       a_hue_q;
  logic [HUE_RECIP_W-1:0] a_hq_q;
  logic [PCT_CLIP_W-1:0]  a_sat_q, a_lig_q;
  logic [PCT_CLIP_W-1:0]  a_sat_d, a_lig_d;
  logic [HP_W-1:0]        a_hp;

  // stage B: hue mod 360, percent quotient estimates
  logic                   b_vld_q;
  logic [HUE_MOD_W-1:0]   b_hmod_q, b_hmod_d;
  logic [PCT_CLIP_W-1:0]  b_sat_q, b_lig_q;
  logic [LW-1:0]          b_qs_q, b_ql_q, b_qs_d, b_ql_d;
  logic [HUE_W:0]         b_hsub, b_hrem;
  logic [PSH+LW-1:0]      b_ps, b_pl;

  // stage C: percent correction, hue fraction estimate
  logic                   c_vld_q;
  logic [LW-1:0]          c_s_q, c_l_q, c_s_d, c_l_d;
  logic [HUE_MOD_W-1:0]   c_hmod_q;
  logic [LW-1:0]          c_qh_q, c_qh_d;
  logic [PSH-1:0]         c_rs, c_rl;
  logic [HSH+LW-1:0]      c_ph;

  // stage D: hue fraction correction
  logic                   d_vld_q;
  logic [LW-1:0]          d_h_q, d_h_d, d_s_q, d_l_q;
  logic [HSH-1:0]         d_rh;

  // stage E: channel hues
  logic                            e_vld_q;
  logic [NUM_CH-1:0][LW-1:0]       e_c_q, e_c_d;
  logic [LW-1:0]                   e_s_q, e_l_q, e_red_sum;

  // stage F: segment and slope factor
  logic                            f_vld_q;
  seg_vec_t                        f_seg_q, f_seg_d;
  logic [NUM_CH-1:0][LW-1:0]       f_m_q, f_m_d;
  logic [LW-1:0]                   f_s_q, f_l_q;

  always_comb begin
    a_sat_d = (saturation_i > PCT_W'(PCT_MAX)) ? PCT_CLIP_W'(PCT_MAX)
                                               : saturation_i[PCT_CLIP_W-1:0];
    a_lig_d = (lightness_i > PCT_W'(PCT_MAX)) ? PCT_CLIP_W'(PCT_MAX)
                                              : lightness_i[PCT_CLIP_W-1:0];
    a_hp    = HP_W'(hue_i) * HP_W'(HUE_RECIP);
  end

  always_comb begin
    b_hsub   = (HUE_W+1)'(a_hq_q) * (HUE_W+1)'(DEG_FULL);
    b_hrem   = {1'b0, a_hue_q} - b_hsub;
    b_hmod_d = (b_hrem >= (HUE_W+1)'(DEG_FULL)) ? HUE_MOD_W'(b_hrem - (HUE_W+1)'(DEG_FULL))
                                                : HUE_MOD_W'(b_hrem);
    b_ps     = (PSH+LW)'({a_sat_q, {FRAC_BITS{1'b0}}}) * (PSH+LW)'(RECIP_PCT);
    b_pl     = (PSH+LW)'({a_lig_q, {FRAC_BITS{1'b0}}}) * (PSH+LW)'(RECIP_PCT);
    b_qs_d   = b_ps[PSH+LW-1:PSH];
    b_ql_d   = b_pl[PSH+LW-1:PSH];
  end

  always_comb begin
    c_rs   = {b_sat_q, {FRAC_BITS{1'b0}}} - PSH'(b_qs_q) * PSH'(PCT_MAX);
    c_rl   = {b_lig_q, {FRAC_BITS{1'b0}}} - PSH'(b_ql_q) * PSH'(PCT_MAX);
    c_s_d  = (c_rs >= PSH'(PCT_MAX)) ? b_qs_q + LW'(1) : b_qs_q;
    c_l_d  = (c_rl >= PSH'(PCT_MAX)) ? b_ql_q + LW'(1) : b_ql_q;
    c_ph   = (HSH+LW)'({b_hmod_q, {FRAC_BITS{1'b0}}}) * (HSH+LW)'(RECIP_DEG);
    c_qh_d = c_ph[HSH+LW-1:HSH];
  end

  always_comb begin
    d_rh  = {c_hmod_q, {FRAC_BITS{1'b0}}} - HSH'(c_qh_q) * HSH'(DEG_FULL);
    d_h_d = (d_rh >= HSH'(DEG_FULL)) ? c_qh_q + LW'(1) : c_qh_q;
  end

  always_comb begin
    e_red_sum        = d_h_q + THIRD;
    e_c_d[CH_GREEN]  = d_h_q;
    e_c_d[CH_RED]    = (e_red_sum > ONE) ? e_red_sum - ONE : e_red_sum;
    e_c_d[CH_BLUE]   = (d_h_q < THIRD) ? d_h_q + (ONE - THIRD) : d_h_q - THIRD;
  end

  always_comb begin
    logic [LW+2:0] c6;
    logic [LW:0]   c2;
    logic [LW+1:0] c3;
    logic [LW-1:0] w;
    logic [LW+2:0] w6;
    for (int k = 0; k < NUM_CH; k++) begin
      c6 = (LW+3)'(e_c_q[k]) * (LW+3)'(6);
      c2 = {e_c_q[k], 1'b0};
      c3 = (LW+2)'(e_c_q[k]) * (LW+2)'(3);
      w  = TWO3 - e_c_q[k];
      w6 = (LW+3)'(w) * (LW+3)'(6);
      priority if (c6 < (LW+3)'(ONE)) begin
        f_seg_d[k] = SEG_RISE;
        f_m_d[k]   = LW'(c6);
      end else if (c2 < (LW+1)'(ONE)) begin
        f_seg_d[k] = SEG_HIGH;
        f_m_d[k]   = '0;
      end else if (c3 < ((LW+2)'(ONE) << 1)) begin
        f_seg_d[k] = SEG_FALL;
        f_m_d[k]   = LW'(w6);
      end else begin
        f_seg_d[k] = SEG_LOW;
        f_m_d[k]   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= accept_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_hue_q  <= hue_i;
      a_hq_q   <= a_hp[HP_W-1:HUE_W];
      a_sat_q  <= a_sat_d;
      a_lig_q  <= a_lig_d;
      b_hmod_q <= b_hmod_d;
      b_sat_q  <= a_sat_q;
      b_lig_q  <= a_lig_q;
      b_qs_q   <= b_qs_d;
      b_ql_q   <= b_ql_d;
      c_s_q    <= c_s_d;
      c_l_q    <= c_l_d;
      c_hmod_q <= b_hmod_q;
      c_qh_q   <= c_qh_d;
      d_h_q    <= d_h_d;
      d_s_q    <= c_s_q;
      d_l_q    <= c_l_q;
      e_c_q    <= e_c_d;
      e_s_q    <= d_s_q;
      e_l_q    <= d_l_q;
      f_seg_q  <= f_seg_d;
      f_m_q    <= f_m_d;
      f_s_q    <= e_s_q;
      f_l_q    <= e_l_q;
    end
  end

  assign valid_o = f_vld_q;
  assign s_o     = f_s_q;
  assign l_o     = f_l_q;
  assign seg_o   = f_seg_q;
  assign m_o     = f_m_q;

endmodule

[design/hsl2rgb_queue.sv]
`timescale 1ns / 1ps
// Small show-ahead FIFO between front end and back end.
// Uses hsl2rgb_pkg for the status struct.
module hsl2rgb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hsl2rgb_pkg::QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       data_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       data_o,
  output hsl2rgb_pkg::q_status_t status_o
);
  import hsl2rgb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o          = mem_q[rd_ptr_q];
  assign status_o.full   = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty  = (cnt_q == '0);

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full))
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && status_o.empty))
    else $error("queue pop while empty");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && status_o.empty) |=> !status_o.empty)
    else $error("queue lost a pushed item");

  a_full_drains_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |=> !status_o.empty)
    else $error("queue drained more than one item per cycle");

endmodule

[design/hsl2rgb_back.sv]
`timescale 1ns / 1ps
// Back end: helper levels, per-channel curve evaluation and byte scaling.
// Uses hsl2rgb_pkg.
module hsl2rgb_back #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  input  logic [FRAC_BITS:0]                            s_i,
  input  logic [FRAC_BITS:0]                            l_i,
  input  hsl2rgb_pkg::seg_vec_t                         seg_i,
  input  logic [hsl2rgb_pkg::NUM_CH-1:0][FRAC_BITS:0]   m_i,
  output logic                                          valid_o,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]                red_o,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]                green_o,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]                blue_o
);
  import hsl2rgb_pkg::*;

  localparam int LW       = FRAC_BITS + 1;
  localparam int BACK_LAT = 7;
  localparam logic [LW-1:0] ONE  = LW'(64'd1 << FRAC_BITS);
  localparam logic [LW-1:0] HALF = LW'(64'd1 << (FRAC_BITS - 1));

  logic [BACK_LAT-1:0] vld_q;

  // B1: l*s
  logic [LW-1:0]             b1_p_q, b1_l_q, b1_s_q;
  seg_vec_t                  b1_seg_q;
  logic [NUM_CH-1:0][LW-1:0] b1_m_q;
  logic [2*LW-1:0]           b1_ls;
  // B2: t1
  logic [LW-1:0]             b2_t1_q, b2_l_q, b2_t1_d;
  seg_vec_t                  b2_seg_q;
  logic [NUM_CH-1:0][LW-1:0] b2_m_q;
  logic [LW:0]               b2_sum;
  // B3: t2
  logic [LW-1:0]             b3_t1_q, b3_t2_q, b3_t2_d;
  seg_vec_t                  b3_seg_q;
  logic [NUM_CH-1:0][LW-1:0] b3_m_q;
  logic [LW:0]               b3_two_l, b3_diff;
  // B4: t1 - t2
  logic [LW-1:0]             b4_d_q, b4_t1_q, b4_t2_q, b4_d_d;
  seg_vec_t                  b4_seg_q;
  logic [NUM_CH-1:0][LW-1:0] b4_m_q;
  // B5: slope products
  logic [NUM_CH-1:0][LW-1:0] b5_prod_q, b5_prod_d;
  logic [LW-1:0]             b5_t1_q, b5_t2_q;
  seg_vec_t                  b5_seg_q;
  // B6: levels
  logic [NUM_CH-1:0][LW-1:0] b6_v_q, b6_v_d;
  // B7: bytes
  logic [NUM_CH-1:0][BYTE_W-1:0] b7_byte_q, b7_byte_d;

  assign b1_ls = (2*LW)'(l_i) * (2*LW)'(s_i);

  always_comb begin
    b2_sum  = (b1_l_q < HALF) ? (LW+1)'(b1_l_q) + (LW+1)'(b1_p_q)
                              : (LW+1)'(b1_l_q) + (LW+1)'(b1_s_q) - (LW+1)'(b1_p_q);
    b2_t1_d = (b2_sum > (LW+1)'(ONE)) ? ONE : LW'(b2_sum);
  end

  always_comb begin
    b3_two_l = {b2_l_q, 1'b0};
    b3_diff  = b3_two_l - (LW+1)'(b2_t1_q);
    if ((LW+1)'(b2_t1_q) > b3_two_l) begin
      b3_t2_d = '0;
    end else if (b3_diff > (LW+1)'(ONE)) begin
      b3_t2_d = ONE;
    end else begin
      b3_t2_d = LW'(b3_diff);
    end
  end

  assign b4_d_d = (b3_t1_q > b3_t2_q) ? b3_t1_q - b3_t2_q : '0;

  always_comb begin
    logic [2*LW-1:0] pr;
    for (int k = 0; k < NUM_CH; k++) begin
      pr           = (2*LW)'(b4_d_q) * (2*LW)'(b4_m_q[k]);
      b5_prod_d[k] = pr[FRAC_BITS +: LW];
    end
  end

  always_comb begin
    logic [LW:0] v;
    for (int k = 0; k < NUM_CH; k++) begin
      unique case (b5_seg_q[k])
        SEG_RISE, SEG_FALL: v = (LW+1)'(b5_t2_q) + (LW+1)'(b5_prod_q[k]);
        SEG_HIGH:           v = (LW+1)'(b5_t1_q);
        SEG_LOW:            v = (LW+1)'(b5_t2_q);
        default:            v = (LW+1)'(b5_t2_q);
      endcase
      b6_v_d[k] = (v > (LW+1)'(ONE)) ? ONE : LW'(v);
    end
  end

  always_comb begin
    logic [LW+BYTE_W-1:0] sc;
    logic [BYTE_W:0]      by;
    for (int k = 0; k < NUM_CH; k++) begin
      sc           = {b6_v_q[k], {BYTE_W{1'b0}}} - (LW+BYTE_W)'(b6_v_q[k]);
      by           = sc[FRAC_BITS +: (BYTE_W+1)];
      b7_byte_d[k] = (by > (BYTE_W+1)'(BYTE_MAX)) ? BYTE_W'(BYTE_MAX) : by[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[BACK_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    b1_p_q    <= b1_ls[FRAC_BITS +: LW];
    b1_l_q    <= l_i;
    b1_s_q    <= s_i;
    b1_seg_q  <= seg_i;
    b1_m_q    <= m_i;
    b2_t1_q   <= b2_t1_d;
    b2_l_q    <= b1_l_q;
    b2_seg_q  <= b1_seg_q;
    b2_m_q    <= b1_m_q;
    b3_t1_q   <= b2_t1_q;
    b3_t2_q   <= b3_t2_d;
    b3_seg_q  <= b2_seg_q;
    b3_m_q    <= b2_m_q;
    b4_d_q    <= b4_d_d;
    b4_t1_q   <= b3_t1_q;
    b4_t2_q   <= b3_t2_q;
    b4_seg_q  <= b3_seg_q;
    b4_m_q    <= b3_m_q;
    b5_prod_q <= b5_prod_d;
    b5_t1_q   <= b4_t1_q;
    b5_t2_q   <= b4_t2_q;
    b5_seg_q  <= b4_seg_q;
    b6_v_q    <= b6_v_d;
    b7_byte_q <= b7_byte_d;
  end

  assign valid_o = vld_q[BACK_LAT-1];
  assign red_o   = b7_byte_q[CH_RED];
  assign green_o = b7_byte_q[CH_GREEN];
  assign blue_o  = b7_byte_q[CH_BLUE];

  a_back_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##BACK_LAT valid_o)
    else $error("back end dropped an item");

endmodule

[design/hsl_to_rgb_converter_top.sv]
`timescale 1ns / 1ps
// Top level of the HSL to RGB converter: front end, queue, back end.
// Uses hsl2rgb_pkg, hsl2rgb_front, hsl2rgb_queue, hsl2rgb_back.
//
//  channel   handshake          payload
//  -------   ---------          -------
//  command   start_i / busy_o   hue_i, saturation_i, lightness_i
//  result    valid_o (strobe)   red_o, green_o, blue_o
//
// One item per clock sustained; the result strobe follows accept through
// 6 front stages, 1 queue slot and 7 back stages.
// busy_o is high only while the two-entry queue is full; the back end pops
// whenever the queue is not empty and never stalls, as results cannot be held off.
// Reset clears all valid flags and the queue pointers.
module hsl_to_rgb_converter_top #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]   hue_i,
  input  logic [hsl2rgb_pkg::PCT_W-1:0]   saturation_i,
  input  logic [hsl2rgb_pkg::PCT_W-1:0]   lightness_i,
  output logic                            valid_o,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]  red_o,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]  green_o,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]  blue_o
);
  import hsl2rgb_pkg::*;

  localparam int LW     = FRAC_BITS + 1;
  localparam int SEG_VW = $bits(seg_vec_t);
  localparam int M_W    = NUM_CH * LW;
  localparam int ITEM_W = 2 * LW + SEG_VW + M_W;

  logic                      en;
  logic                      accept;
  q_status_t                 q_status;
  logic                      fr_valid;
  logic [LW-1:0]             fr_s, fr_l;
  seg_vec_t                  fr_seg;
  logic [NUM_CH-1:0][LW-1:0] fr_m;
  logic                      push, pop;
  logic [ITEM_W-1:0]         push_data, pop_data;
  logic [LW-1:0]             bk_s, bk_l;
  seg_vec_t                  bk_seg;
  logic [NUM_CH-1:0][LW-1:0] bk_m;

  assign en     = !q_status.full;
  assign busy_o = q_status.full;
  assign accept = start_i && !busy_o;
  assign push   = fr_valid && en;
  assign pop    = !q_status.empty;

  assign push_data = {fr_s, fr_l, fr_seg, fr_m};
  assign bk_s      = pop_data[ITEM_W-1 -: LW];
  assign bk_l      = pop_data[ITEM_W-LW-1 -: LW];
  assign bk_seg    = seg_vec_t'(pop_data[M_W +: SEG_VW]);
  assign bk_m      = pop_data[M_W-1:0];

  hsl2rgb_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .accept_i    (accept),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .lightness_i (lightness_i),
    .valid_o     (fr_valid),
    .s_o         (fr_s),
    .l_o         (fr_l),
    .seg_o       (fr_seg),
    .m_o         (fr_m)
  );

  hsl2rgb_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (pop_data),
    .status_o(q_status)
  );

  hsl2rgb_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(pop),
    .s_i    (bk_s),
    .l_i    (bk_l),
    .seg_i  (bk_seg),
    .m_i    (bk_m),
    .valid_o(valid_o),
    .red_o  (red_o),
    .green_o(green_o),
    .blue_o (blue_o)
  );

endmodule

[test/tb_hsl_to_rgb_converter_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hsl_to_rgb_converter_top: directed and random colors,
// each result compared against a fixed-point HSL to RGB predictor.
// Depends on hsl2rgb_pkg and the converter RTL.
module tb_hsl_to_rgb_converter_top;
  import hsl2rgb_pkg::*;

  localparam int     FB          = FRAC_BITS_DEF;
  localparam longint FX_ONE      = longint'(1) << FB;
  localparam longint FX_HALF     = FX_ONE / 2;
  localparam longint FX_THIRD    = FX_ONE / 3;
  localparam longint FX_TWO3     = (2 * FX_ONE) / 3;
  localparam int     PIPE_LAT    = 14;
  localparam int     CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [HUE_W-1:0]  hue_i;
  logic [PCT_W-1:0]  saturation_i;
  logic [PCT_W-1:0]  lightness_i;
  logic              valid_o;
  logic [BYTE_W-1:0] red_o;
  logic [BYTE_W-1:0] green_o;
  logic [BYTE_W-1:0] blue_o;

  rgb_t expected_rgb_q[$];
  int   error_count = 0;
  int   cycle_count = 0;
  int   sender_idle_pct = 0;

  hsl_to_rgb_converter_top #(
    .FRAC_BITS(FB)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .lightness_i (lightness_i),
    .valid_o     (valid_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic longint fx_product(longint a, longint b);
    if (a < 0) a = 0;
    if (b < 0) b = 0;
    return (a * b) >>> FB;
  endfunction

  function automatic longint fx_clip(longint v);
    if (v < 0) return 0;
    if (v > FX_ONE) return FX_ONE;
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] level_byte(longint v);
    longint r;
    r = (fx_clip(v) * BYTE_MAX) >>> FB;
    if (r > BYTE_MAX) r = BYTE_MAX;
    return r[BYTE_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] channel_byte(longint c, longint t1, longint t2);
    longint d;
    longint v;
    longint w;
    d = t1 - t2;
    if (d < 0) d = 0;
    if (c < 0) c = c + FX_ONE;
    else if (c > FX_ONE) c = c - FX_ONE;
    if (6 * c < FX_ONE) begin
      v = t2 + fx_product(d, 6 * c);
    end else if (2 * c < FX_ONE) begin
      v = t1;
    end else if (3 * c < 2 * FX_ONE) begin
      w = FX_TWO3 - c;
      if (w < 0) w = 0;
      v = t2 + fx_product(d, 6 * w);
    end else begin
      v = t2;
    end
    return level_byte(v);
  endfunction

  function automatic rgb_t hsl_to_rgb_predict(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                                              logic [PCT_W-1:0] lig);
    longint sat_c;
    longint lig_c;
    longint h;
    longint s;
    longint l;
    longint t1;
    longint t2;
    rgb_t   res;
    sat_c = (sat > PCT_MAX) ? PCT_MAX : longint'(sat);
    lig_c = (lig > PCT_MAX) ? PCT_MAX : longint'(lig);
    h = ((longint'(hue) % DEG_FULL) << FB) / DEG_FULL;
    s = (sat_c << FB) / PCT_MAX;
    l = (lig_c << FB) / PCT_MAX;
    if (sat_c == 0) begin
      res.red   = level_byte(l);
      res.green = res.red;
      res.blue  = res.red;
      return res;
    end
    if (l < FX_HALF) t1 = fx_product(l, FX_ONE + s);
    else t1 = l + s - fx_product(l, s);
    t1 = fx_clip(t1);
    t2 = fx_clip(2 * l - t1);
    res.red   = channel_byte(h + FX_THIRD, t1, t2);
    res.green = channel_byte(h, t1, t2);
    res.blue  = channel_byte(h - FX_THIRD, t1, t2);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // accepted items queue their prediction; each strobe is checked against the oldest
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_rgb_q.push_back(hsl_to_rgb_predict(hue_i, saturation_i, lightness_i));
      end
      if (valid_o) begin
        if (expected_rgb_q.size() == 0) begin
          report_mismatch("unexpected result, red", red_o, 0);
        end else begin
          want = expected_rgb_q.pop_front();
          if (red_o !== want.red) report_mismatch("red", red_o, want.red);
          if (green_o !== want.green) report_mismatch("green", green_o, want.green);
          if (blue_o !== want.blue) report_mismatch("blue", blue_o, want.blue);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic sender_gap();
    if ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      while ($urandom_range(99) < sender_idle_pct) @(negedge clk_i);
    end
  endtask

  task automatic send_item(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                           logic [PCT_W-1:0] lig);
    sender_gap();
    @(negedge clk_i);
    start_i      <= 1'b1;
    hue_i        <= hue;
    saturation_i <= sat;
    lightness_i  <= lig;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_rgb_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_hue_wrap();
    send_item(0, 100, 50);
    send_item(60, 100, 50);
    send_item(120, 100, 50);
    send_item(180, 100, 50);
    send_item(240, 100, 50);
    send_item(300, 100, 50);
    send_item(359, 100, 50);
    send_item(360, 100, 50);
    send_item(719, 100, 50);
    send_item(16'hFFFF, 100, 50);
  endtask

  task automatic test_percent_clip();
    send_item(30, 255, 50);
    send_item(30, 101, 50);
    send_item(30, 50, 101);
    send_item(30, 50, 255);
    send_item(30, 255, 255);
    send_item(30, 100, 100);
  endtask

  task automatic test_zero_saturation();
    send_item(200, 0, 0);
    send_item(200, 0, 25);
    send_item(200, 0, 50);
    send_item(200, 0, 100);
    send_item(16'hFFFF, 0, 255);
  endtask

  // lightness around one half switches the helper-level formula; lightness 0 and 99 are also sent
  task automatic test_level_boundaries();
    send_item(240, 100, 49);
    send_item(240, 100, 50);
    send_item(90, 100, 0);
    send_item(241, 1, 99);
  endtask

  task automatic test_random(int count, int idle_pct);
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] lig;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      hue = ($urandom_range(1) == 0) ? HUE_W'($urandom_range(359)) : HUE_W'($urandom_range(65535));
      if ($urandom_range(9) == 0) sat = '0;
      else if ($urandom_range(9) < 7) sat = PCT_W'($urandom_range(PCT_MAX));
      else sat = PCT_W'($urandom_range(255));
      if ($urandom_range(9) < 7) lig = PCT_W'($urandom_range(PCT_MAX));
      else lig = PCT_W'($urandom_range(255));
      send_item(hue, sat, lig);
    end
  endtask

  task automatic test_drain_pause();
    wait_for_results();
    send_item(HUE_W'($urandom_range(65535)), PCT_W'($urandom_range(255)),
              PCT_W'($urandom_range(255)));
  endtask

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    hue_i        = '0;
    saturation_i = '0;
    lightness_i  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    sender_idle_pct = 8;
    test_hue_wrap();
    test_percent_clip();
    test_zero_saturation();
    test_level_boundaries();
    test_random(150, 8);
    test_drain_pause();
    test_random(150, 79);
    test_drain_pause();
    test_random(150, 0);

    wait_for_results();
    repeat (2 * PIPE_LAT) @(posedge clk_i);
    if (error_count == 0 && expected_rgb_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
